// ----- hw/rtl/sbpd_pkg.sv -----
// sbpd_pkg: shared types and constants for the six-button pad decoder
// no dependencies

package sbpd_pkg;

    localparam int POLLS_PER_FRAME_DEF = 4;
    localparam int NUM_PADS            = 2;
    localparam int PAD_STRIDE          = 16;
    localparam int MAP_W               = 12;
    localparam int FORCED_3BTN_POLLS   = 2;
    localparam logic [3:0] NIBBLE_MASK = 4'b1111;

    localparam int LINE_UP    = 0;
    localparam int LINE_DOWN  = 1;
    localparam int LINE_ID_LO = 2;
    localparam int LINE_ID_HI = 3;
    localparam int LINE_A     = 4;
    localparam int LINE_START = 5;
    localparam int LINE_Z     = 8;
    localparam int LINE_Y     = 9;
    localparam int LINE_LEFT  = 10;
    localparam int LINE_RIGHT = 11;
    localparam int LINE_B     = 12;
    localparam int LINE_C     = 13;

    localparam int BTN_A     = 0;
    localparam int BTN_B     = 1;
    localparam int BTN_C     = 2;
    localparam int BTN_X     = 3;
    localparam int BTN_Y     = 4;
    localparam int BTN_Z     = 5;
    localparam int BTN_START = 6;
    localparam int BTN_MODE  = 7;
    localparam int BTN_UP    = 8;
    localparam int BTN_DOWN  = 9;
    localparam int BTN_LEFT  = 10;
    localparam int BTN_RIGHT = 11;

    typedef struct packed {
        logic [MAP_W-1:0] map;
        logic             present;
    } lane_result_t;

endpackage

// ----- hw/rtl/sbpd_lane.sv -----
// sbpd_lane: decodes one pad's 16-bit half into a button map and presence bit
// depends on sbpd_pkg

module sbpd_lane (
    input  logic [sbpd_pkg::PAD_STRIDE-1:0] half,
    input  logic                            force_three,
    output sbpd_pkg::lane_result_t          result
);
    import sbpd_pkg::*;

    logic [PAD_STRIDE-1:0] pulled;
    logic                  three_btn;

    assign pulled    = ~half;
    assign three_btn = force_three || ((half[3:0] & NIBBLE_MASK) != 4'b0000);

    always_comb
    begin
        result.map     = '0;
        result.present = 1'b0;
        result.map[BTN_A]     = pulled[LINE_A];
        result.map[BTN_START] = pulled[LINE_START];
        if (three_btn)
        begin
            result.map[BTN_UP]    = pulled[LINE_UP];
            result.map[BTN_DOWN]  = pulled[LINE_DOWN];
            result.map[BTN_LEFT]  = pulled[LINE_LEFT];
            result.map[BTN_RIGHT] = pulled[LINE_RIGHT];
            result.map[BTN_B]     = pulled[LINE_B];
            result.map[BTN_C]     = pulled[LINE_C];
            result.present        = pulled[LINE_ID_LO] | pulled[LINE_ID_HI];
        end
        else
        begin
            result.map[BTN_Z]    = pulled[LINE_Z];
            result.map[BTN_Y]    = pulled[LINE_Y];
            result.map[BTN_X]    = pulled[LINE_LEFT];
            result.map[BTN_MODE] = pulled[LINE_RIGHT];
        end
    end

endmodule

// ----- hw/rtl/sbpd_merge.sv -----
// sbpd_merge: frame counter, per-pad accumulation of lane results, output register
// depends on sbpd_pkg

module sbpd_merge #(
    parameter int POLLS_PER_FRAME = sbpd_pkg::POLLS_PER_FRAME_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  sbpd_pkg::lane_result_t       lane_res [sbpd_pkg::NUM_PADS],
    output logic                         force_three,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [sbpd_pkg::MAP_W-1:0]   pad0_buttons,
    output logic [sbpd_pkg::MAP_W-1:0]   pad1_buttons,
    output logic                         pad0_present,
    output logic                         pad1_present
);
    import sbpd_pkg::*;

    localparam int CNT_W = $clog2(POLLS_PER_FRAME);
    localparam logic [CNT_W-1:0] LAST_POLL = CNT_W'(POLLS_PER_FRAME - 1);
    localparam logic [CNT_W-1:0] FORCED    = CNT_W'(FORCED_3BTN_POLLS);

    logic [CNT_W-1:0] poll_count_reg, poll_count_next;
    logic [MAP_W-1:0] acc_reg [NUM_PADS];
    logic [MAP_W-1:0] acc_next [NUM_PADS];
    logic [MAP_W-1:0] merged [NUM_PADS];
    logic [NUM_PADS-1:0] seen_reg, seen_next, seen_merged;
    logic out_valid_reg, out_valid_next;
    logic [MAP_W-1:0] pad0_reg, pad1_reg;
    logic pres0_reg, pres1_reg;
    logic in_accept, last_poll, emit;

    assign last_poll   = (poll_count_reg == LAST_POLL);
    assign in_stall    = out_valid_reg && out_stall && last_poll;
    assign in_accept   = in_valid && !in_stall;
    assign emit        = in_accept && last_poll;
    assign force_three = (poll_count_reg < FORCED);

    always_comb
    begin
        for (int d = 0; d < NUM_PADS; d++)
        begin
            merged[d]      = acc_reg[d] | lane_res[d].map;
            seen_merged[d] = seen_reg[d] | lane_res[d].present;
        end
        poll_count_next = poll_count_reg;
        seen_next       = seen_reg;
        for (int d = 0; d < NUM_PADS; d++)
        begin
            acc_next[d] = acc_reg[d];
        end
        if (in_accept)
        begin
            if (last_poll)
            begin
                poll_count_next = '0;
                seen_next       = '0;
                for (int d = 0; d < NUM_PADS; d++)
                begin
                    acc_next[d] = '0;
                end
            end
            else
            begin
                poll_count_next = poll_count_reg + 1'b1;
                seen_next       = seen_merged;
                for (int d = 0; d < NUM_PADS; d++)
                begin
                    acc_next[d] = merged[d];
                end
            end
        end
        out_valid_next = out_valid_reg && out_stall;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_count_reg <= '0;
            seen_reg       <= '0;
            out_valid_reg  <= 1'b0;
            for (int d = 0; d < NUM_PADS; d++)
            begin
                acc_reg[d] <= '0;
            end
        end
        else
        begin
            poll_count_reg <= poll_count_next;
            seen_reg       <= seen_next;
            out_valid_reg  <= out_valid_next;
            for (int d = 0; d < NUM_PADS; d++)
            begin
                acc_reg[d] <= acc_next[d];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            pad0_reg  <= merged[0];
            pad1_reg  <= merged[1];
            pres0_reg <= seen_merged[0];
            pres1_reg <= seen_merged[1];
        end
    end

    assign out_valid    = out_valid_reg;
    assign pad0_buttons = pad0_reg;
    assign pad1_buttons = pad1_reg;
    assign pad0_present = pres0_reg;
    assign pad1_present = pres1_reg;

endmodule

// ----- hw/rtl/six_button_pad_decoder.sv -----
// six_button_pad_decoder: top level, two decode lanes feeding the frame merge stage
// depends on sbpd_pkg, sbpd_lane, sbpd_merge
//
// One poll word is accepted every cycle that in_stall is low; each of the two pads
// is decoded by its own lane and ORed into its frame map. Every POLLS_PER_FRAME-th
// poll closes the frame and its result appears in the output register on the
// following cycle. Non-closing polls are always taken; the closing poll is stalled
// only while the previous frame's result is held in the output under out_stall.

module six_button_pad_decoder #(
    parameter int POLLS_PER_FRAME = sbpd_pkg::POLLS_PER_FRAME_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [31:0]                   raw_word,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [sbpd_pkg::MAP_W-1:0]    pad0_buttons,
    output logic [sbpd_pkg::MAP_W-1:0]    pad1_buttons,
    output logic                          pad0_present,
    output logic                          pad1_present
);
    import sbpd_pkg::*;

    lane_result_t lane_res [NUM_PADS];
    logic         force_three;

    for (genvar d = 0; d < NUM_PADS; d++)
    begin : g_lane
        sbpd_lane u_lane (
            .half        (raw_word[d*PAD_STRIDE +: PAD_STRIDE]),
            .force_three (force_three),
            .result      (lane_res[d])
        );
    end

    sbpd_merge #(
        .POLLS_PER_FRAME (POLLS_PER_FRAME)
    ) u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .lane_res     (lane_res),
        .force_three  (force_three),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pad0_buttons (pad0_buttons),
        .pad1_buttons (pad1_buttons),
        .pad0_present (pad0_present),
        .pad1_present (pad1_present)
    );

endmodule

// ----- hw/rtl/sbpd_checker.sv -----
// sbpd_checker: port-level assertions for the six-button pad decoder, bound to the top
// depends on sbpd_pkg and six_button_pad_decoder

module sbpd_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [sbpd_pkg::MAP_W-1:0]    pad0_buttons,
    input  logic [sbpd_pkg::MAP_W-1:0]    pad1_buttons,
    input  logic                          pad0_present,
    input  logic                          pad1_present
);
    import sbpd_pkg::*;

    // result held while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(pad0_buttons) && $stable(pad1_buttons)
            && $stable(pad0_present) && $stable(pad1_present))
        else $error("stalled result changed");

    // a new result only follows an accepted item
    a_rise_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall))
        else $error("result without accepted item");

    // input stalls only behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with output free");

endmodule

bind six_button_pad_decoder sbpd_checker u_sbpd_checker (.*);
